/* src/c8x_pkg.sv */
// ----------------------------------------------------------------------------
// c8x_pkg
// Shared types and constants for the CHIP-8 execute unit.
// ----------------------------------------------------------------------------
package c8x_pkg;

  localparam int MemDepthDef   = 4096;
  localparam int StackDepthDef = 16;
  localparam int GlyphHeight   = 5;

  localparam logic [11:0] StartAddrRst = 12'd512;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_LEFT_OUT  = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_UNDERFLOW = 3'd3;
  localparam logic [2:0] ST_UNKNOWN   = 3'd4;

  localparam logic [0:0] REG_START_ADDRESS = 1'd0;

  typedef struct packed {
    logic        mode;
    logic [11:0] load_address;
    logic [7:0]  load_data;
    logic [15:0] opcode;
    logic [15:0] key_mask;
    logic [7:0]  random_byte;
  } in_item_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [15:0] index_value;
    logic [7:0]  flag_value;
    logic [7:0]  delay_value;
    logic [7:0]  sound_value;
    logic [2:0]  status;
  } out_item_t;

  // BCD digits of a byte: {hundreds, tens, ones}
  function automatic logic [11:0] bcd8(input logic [7:0] v);
    logic [7:0] h;
    logic [7:0] r;
    logic [7:0] t;
    h = (v >= 8'd200) ? 8'd2 : (v >= 8'd100) ? 8'd1 : 8'd0;
    r = v - h * 8'd100;
    t = 8'((16'(r) * 16'd205) >> 11);
    bcd8 = {h[3:0], t[3:0], 4'(r - t * 8'd10)};
  endfunction

endpackage

/* src/c8x_regfile.sv */
// ----------------------------------------------------------------------------
// c8x_regfile
// V0..VF register file: synchronous RAM with per-entry valid bits so that
// reset reads as zero.
// ----------------------------------------------------------------------------
module c8x_regfile (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [3:0] raddr,
  output logic [7:0] rdata,
  input  logic       we,
  input  logic [3:0] waddr,
  input  logic [7:0] wdata
);

  logic [7:0]  mem [16];
  logic [15:0] vld_r;
  logic [7:0]  rd_r;
  logic        rv_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rv_r  <= 1'b0;
    end else begin
      rv_r <= vld_r[raddr];
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rv_r ? rd_r : 8'd0;

endmodule

/* src/chip8_instruction_execute_core.sv */
// ----------------------------------------------------------------------------
// chip8_instruction_execute_core
// CHIP-8 execute unit: memory byte loads and opcode execution.
// ----------------------------------------------------------------------------
// One item is worked at a time. A memory load goes to S_DONE, where its byte
// is written and its result beat is set up. Most opcodes read Vx, Vy (V0 for
// Bnnn) and VF, then execute. The 8xyN group adds a flag write, then a Vx
// write, and BCD store adds one memory write per digit. Block store and load
// Fx55/Fx65 walk the single port of the register file and the single port of
// main memory one register per step. The core returns to S_IDLE before the
// next item is taken. The result sits in an output register; the next item is
// taken no earlier than the cycle in which that result beat leaves.
// Register 0 (start_address, byte 0) also reloads the program counter.
module chip8_instruction_execute_core #(
  parameter int MEM_DEPTH   = c8x_pkg::MemDepthDef,
  parameter int STACK_DEPTH = c8x_pkg::StackDepthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  c8x_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output c8x_pkg::out_item_t  out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  localparam int MAW = $clog2(MEM_DEPTH);
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SDW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RDX   = 9'b000000010,
    S_RDY   = 9'b000000100,
    S_EXEC  = 9'b000001000,
    S_BCD   = 9'b000010000,
    S_BLKR  = 9'b000100000,
    S_BLKW  = 9'b001000000,
    S_DONE  = 9'b010000000,
    S_MEMRD = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  c8x_pkg::in_item_t in_r;
  logic [11:0] start_r, pc_r;
  logic [15:0] idx_r;
  logic [7:0]  dt_r, st_r, vf_r, vx_r, vy_r;
  logic [SDW-1:0] sd_r;
  logic [3:0]  cnt_r;
  logic [1:0]  bcd_r;
  logic [2:0]  status_r;
  logic        ov_r;
  c8x_pkg::out_item_t od_r;

  logic [11:0] stk [STACK_DEPTH];
  logic [11:0] stk_rd_r;
  logic [7:0]  mem [MEM_DEPTH];
  logic [7:0]  mem_rd_r;
  logic        mem_we;
  logic [MAW-1:0] mem_wa, mem_ra;
  logic [7:0]  mem_wd;

  logic [3:0] rf_ra, rf_wa;
  logic [7:0] rf_rd, rf_wd;
  logic       rf_we;

  c8x_regfile u_rf (
    .clk(clk), .rst_n(rst_n), .raddr(rf_ra), .rdata(rf_rd),
    .we(rf_we), .waddr(rf_wa), .wdata(rf_wd)
  );

  logic [15:0] op;
  logic [3:0]  ox, oy, on;
  logic [7:0]  kk;
  logic [11:0] nnn, pc2;
  assign op  = in_r.opcode;
  assign ox  = op[11:8];
  assign oy  = op[7:4];
  assign on  = op[3:0];
  assign kk  = op[7:0];
  assign nnn = op[11:0];
  assign pc2 = pc_r + 12'd2;

  logic fin;
  assign in_stall   = (state_r != S_IDLE) || (ov_r && out_stall);
  assign out_valid  = ov_r;
  assign out_data   = od_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {20'd0, start_r};

  localparam logic REG0_BIT = c8x_pkg::REG_START_ADDRESS;
  logic cfg_we;
  assign cfg_we = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                  (cfg_paddr[2] == REG0_BIT);

  logic [11:0] bcd;
  assign bcd = c8x_pkg::bcd8(vx_r);

  // datapath for EXEC
  logic [8:0] sum;
  logic [7:0] alu_r, alu_f;
  logic       alu_ok;
  always_comb begin
    sum    = {1'b0, vx_r} + {1'b0, vy_r};
    alu_r  = vy_r;
    alu_f  = vf_r;
    alu_ok = 1'b1;
    case (on)
      4'h0: alu_r = vy_r;
      4'h1: alu_r = vx_r | vy_r;
      4'h2: alu_r = vx_r & vy_r;
      4'h3: alu_r = vx_r ^ vy_r;
      4'h4: begin alu_r = sum[7:0]; alu_f = {7'd0, sum[8]}; end
      4'h5: begin alu_r = vx_r - vy_r; alu_f = {7'd0, vx_r > vy_r}; end
      4'h6: begin alu_r = {1'b0, vx_r[7:1]}; alu_f = {7'd0, vx_r[0]}; end
      4'h7: begin alu_r = vy_r - vx_r; alu_f = {7'd0, vy_r > vx_r}; end
      4'hE: begin alu_r = {vx_r[6:0], 1'b0}; alu_f = {7'd0, vx_r[7]}; end
      default: alu_ok = 1'b0;
    endcase
  end

  logic [11:0] pc_nxt;
  logic [15:0] idx_nxt;
  logic [7:0]  dt_nxt, st_nxt, vf_nxt;
  logic [SDW-1:0] sd_nxt;
  logic [2:0]  status_nxt;
  logic        stk_we;
  logic [3:0]  cnt_nxt;
  logic [1:0]  bcd_nxt;
  logic        key;

  assign key = (vx_r[7:4] == 4'd0) && in_r.key_mask[vx_r[3:0]];

  always_comb begin
    state_nxt  = state_r;
    pc_nxt     = pc_r;
    idx_nxt    = idx_r;
    dt_nxt     = dt_r;
    st_nxt     = st_r;
    vf_nxt     = vf_r;
    sd_nxt     = sd_r;
    status_nxt = status_r;
    cnt_nxt    = cnt_r;
    bcd_nxt    = bcd_r;
    stk_we     = 1'b0;
    rf_ra      = ox;
    rf_we      = 1'b0;
    rf_wa      = ox;
    rf_wd      = 8'd0;
    mem_we     = 1'b0;
    mem_wa     = MAW'(in_r.load_address);
    mem_wd     = in_r.load_data;
    mem_ra     = MAW'(idx_r + 16'(cnt_r));
    fin        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // issue the Vx read of the incoming beat
        rf_ra = in_data.opcode[11:8];
        if (in_valid && !in_stall) begin
          state_nxt = in_data.mode ? S_RDX : S_DONE;
        end
      end
      S_RDX: begin
        // Vx read issued; next read Vy, or V0 for Bnnn
        status_nxt = c8x_pkg::ST_OK;
        pc_nxt    = pc2;
        rf_ra     = (op[15:12] == 4'hB) ? 4'h0 : oy;
        state_nxt = S_RDY;
      end
      S_RDY: begin
        rf_ra     = 4'hF;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (op[15:12])
          4'h0: begin
            if (op == 16'h00E0) status_nxt = c8x_pkg::ST_LEFT_OUT;
            else if (op == 16'h00EE) begin
              if (sd_r == '0) status_nxt = c8x_pkg::ST_UNDERFLOW;
              else begin
                sd_nxt = sd_r - 1'b1;
                pc_nxt = stk_rd_r;
              end
            end else status_nxt = c8x_pkg::ST_UNKNOWN;
          end
          4'h1: pc_nxt = nnn;
          4'h2: begin
            if (sd_r >= SDW'(STACK_DEPTH)) status_nxt = c8x_pkg::ST_OVERFLOW;
            else begin
              stk_we = 1'b1;
              sd_nxt = sd_r + 1'b1;
              pc_nxt = nnn;
            end
          end
          4'h3: if (vx_r == kk) pc_nxt = pc_r + 12'd2;
          4'h4: if (vx_r != kk) pc_nxt = pc_r + 12'd2;
          4'h5, 4'h9: begin
            if (on != 4'd0) status_nxt = c8x_pkg::ST_UNKNOWN;
            else if ((vx_r == vy_r) ^ op[15]) pc_nxt = pc_r + 12'd2;
          end
          4'h6: begin rf_we = 1'b1; rf_wd = kk; end
          4'h7: begin rf_we = 1'b1; rf_wd = vx_r + kk; end
          4'h8: begin
            if (!alu_ok) status_nxt = c8x_pkg::ST_UNKNOWN;
            else begin
              // flag first, then Vx so that x == F keeps the result
              rf_we = 1'b1; rf_wa = 4'hF; rf_wd = alu_f;
              state_nxt = S_BLKW;
              cnt_nxt = 4'd0;
            end
          end
          4'hA: idx_nxt = {4'd0, nnn};
          4'hB: pc_nxt = nnn + {4'd0, vy_r};
          4'hC: begin rf_we = 1'b1; rf_wd = in_r.random_byte & kk; end
          4'hD: status_nxt = c8x_pkg::ST_LEFT_OUT;
          4'hE: begin
            if (kk == 8'h9E) begin if (key) pc_nxt = pc_r + 12'd2; end
            else if (kk == 8'hA1) begin if (!key) pc_nxt = pc_r + 12'd2; end
            else status_nxt = c8x_pkg::ST_UNKNOWN;
          end
          default: begin
            case (kk)
              8'h07: begin rf_we = 1'b1; rf_wd = dt_r; end
              8'h0A: status_nxt = c8x_pkg::ST_LEFT_OUT;
              8'h15: dt_nxt = vx_r;
              8'h18: st_nxt = vx_r;
              8'h1E: idx_nxt = idx_r + {8'd0, vx_r};
              8'h29: idx_nxt = 16'(vx_r) * 16'(c8x_pkg::GlyphHeight);
              8'h33: begin bcd_nxt = 2'd0; state_nxt = S_BCD; end
              8'h55: begin cnt_nxt = 4'd0; rf_ra = 4'd0; state_nxt = S_BLKR; end
              8'h65: begin cnt_nxt = 4'd0; state_nxt = S_MEMRD; end
              default: status_nxt = c8x_pkg::ST_UNKNOWN;
            endcase
          end
        endcase
      end
      S_BCD: begin
        mem_we = 1'b1;
        mem_wa = MAW'(idx_r + 16'(bcd_r));
        mem_wd = (bcd_r == 2'd0) ? {4'd0, bcd[11:8]} :
                 (bcd_r == 2'd1) ? {4'd0, bcd[7:4]} : {4'd0, bcd[3:0]};
        bcd_nxt = bcd_r + 2'd1;
        if (bcd_r == 2'd2) state_nxt = S_DONE;
      end
      S_BLKR: begin
        // register read for Fx55 issued last cycle; ALU Vx write for 8xyN
        if (op[15:12] == 4'h8) begin
          rf_we = 1'b1; rf_wd = alu_r;
          vf_nxt = (ox == 4'hF) ? alu_r : alu_f;
          state_nxt = S_DONE;
        end else begin
          rf_ra = cnt_r;
          state_nxt = S_BLKW;
        end
      end
      S_BLKW: begin
        if (op[15:12] == 4'h8) begin
          state_nxt = S_BLKR;
        end else if (kk == 8'h55) begin
          mem_we = 1'b1;
          mem_wa = MAW'(idx_r + 16'(cnt_r));
          mem_wd = rf_rd;
          cnt_nxt = cnt_r + 4'd1;
          rf_ra = cnt_r + 4'd1;
          state_nxt = (cnt_r == ox) ? S_DONE : S_BLKR;
        end else begin
          rf_we = 1'b1; rf_wa = cnt_r; rf_wd = mem_rd_r;
          if (cnt_r == 4'hF) vf_nxt = mem_rd_r;
          cnt_nxt = cnt_r + 4'd1;
          mem_ra = MAW'(idx_r + 16'(cnt_r) + 16'd1);
          state_nxt = (cnt_r == ox) ? S_DONE : S_MEMRD;
        end
      end
      S_MEMRD: begin
        state_nxt = S_BLKW;
      end
      S_DONE: begin
        // a load beat writes its byte here
        mem_we = !in_r.mode;
        fin = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_EXEC && rf_we && rf_wa == 4'hF) begin
      vf_nxt = rf_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid && !in_stall) in_r <= in_data;
    if (state_r == S_RDX)  vx_r <= rf_rd;
    if (state_r == S_RDY)  vy_r <= rf_rd;
    if (stk_we) stk[SAW'(sd_r)] <= pc_r;
    stk_rd_r <= stk[SAW'(sd_r - 1'b1)];
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      start_r  <= c8x_pkg::StartAddrRst;
      pc_r     <= c8x_pkg::StartAddrRst;
      idx_r    <= '0;
      dt_r     <= '0;
      st_r     <= '0;
      vf_r     <= '0;
      sd_r     <= '0;
      cnt_r    <= '0;
      bcd_r    <= '0;
      status_r <= c8x_pkg::ST_OK;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pc_r     <= pc_nxt;
      idx_r    <= idx_nxt;
      dt_r     <= dt_nxt;
      st_r     <= st_nxt;
      vf_r     <= vf_nxt;
      sd_r     <= sd_nxt;
      cnt_r    <= cnt_nxt;
      bcd_r    <= bcd_nxt;
      status_r <= status_nxt;
      if (state_r == S_IDLE && in_valid && !in_stall) status_r <= c8x_pkg::ST_OK;
      if (cfg_we) begin
        start_r <= cfg_pwdata[11:0];
        pc_r    <= cfg_pwdata[11:0];
      end
      if (fin) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      od_r.program_counter <= pc_r;
      od_r.index_value     <= idx_r;
      od_r.flag_value      <= vf_r;
      od_r.delay_value     <= dt_r;
      od_r.sound_value     <= st_r;
      od_r.status          <= status_r;
    end
  end

endmodule

/* sim/chip8_instruction_execute_core_tb.sv */
// ----------------------------------------------------------------------------
// chip8_instruction_execute_core_tb
// Drives memory loads and opcodes into the execute unit, predicts each result
// from a behavioral copy of the machine state and checks every result beat.
// ----------------------------------------------------------------------------
module chip8_instruction_execute_core_tb;

  localparam int CycleLimit = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  c8x_pkg::in_item_t  in_data;
  logic        out_valid;
  logic        out_stall;
  c8x_pkg::out_item_t out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  chip8_instruction_execute_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // machine state copy
  logic [7:0]  vreg [16];
  logic [15:0] ireg;
  logic [11:0] pc;
  logic [11:0] rstack [16];
  int          depth;
  logic [7:0]  dtimer;
  logic [7:0]  stimer;
  logic [7:0]  mem [4096];
  bit          mem_known [4096];

  c8x_pkg::in_item_t  pending_items [$];
  c8x_pkg::out_item_t expected_results [$];
  int        mismatches;
  int        cycles;
  bit        driver_idle_en;
  bit        hold_out;
  int        hold_left;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void skip_when(input bit c);
    if (c) pc = pc + 12'd2;
  endfunction

  function automatic logic [2:0] run_opcode(input logic [15:0] op, input logic [15:0] keys,
                                            input logic [7:0] rnd);
    logic [3:0] x;
    logic [3:0] y;
    logic [3:0] n;
    logic [7:0] kk;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] r;
    logic [7:0] f;
    logic [8:0] s;
    x = op[11:8]; y = op[7:4]; n = op[3:0]; kk = op[7:0];
    pc = pc + 12'd2;
    case (op[15:12])
      4'h0: begin
        if (op == 16'h00E0) return c8x_pkg::ST_LEFT_OUT;
        if (op == 16'h00EE) begin
          if (depth == 0) return c8x_pkg::ST_UNDERFLOW;
          depth--;
          pc = rstack[depth];
          return c8x_pkg::ST_OK;
        end
        return c8x_pkg::ST_UNKNOWN;
      end
      4'h1: pc = op[11:0];
      4'h2: begin
        if (depth >= 16) return c8x_pkg::ST_OVERFLOW;
        rstack[depth] = pc;
        depth++;
        pc = op[11:0];
      end
      4'h3: skip_when(vreg[x] == kk);
      4'h4: skip_when(vreg[x] != kk);
      4'h5: begin
        if (n != 0) return c8x_pkg::ST_UNKNOWN;
        skip_when(vreg[x] == vreg[y]);
      end
      4'h6: vreg[x] = kk;
      4'h7: vreg[x] = vreg[x] + kk;
      4'h8: begin
        a = vreg[x]; b = vreg[y]; f = vreg[15];
        case (n)
          4'h0: r = b;
          4'h1: r = a | b;
          4'h2: r = a & b;
          4'h3: r = a ^ b;
          4'h4: begin s = a + b; f = {7'd0, s[8]}; r = s[7:0]; end
          4'h5: begin f = {7'd0, a > b}; r = a - b; end
          4'h6: begin f = {7'd0, a[0]}; r = a >> 1; end
          4'h7: begin f = {7'd0, b > a}; r = b - a; end
          4'hE: begin f = {7'd0, a[7]}; r = a << 1; end
          default: return c8x_pkg::ST_UNKNOWN;
        endcase
        vreg[15] = f;
        vreg[x] = r;
      end
      4'h9: begin
        if (n != 0) return c8x_pkg::ST_UNKNOWN;
        skip_when(vreg[x] != vreg[y]);
      end
      4'hA: ireg = {4'd0, op[11:0]};
      4'hB: pc = op[11:0] + {4'd0, vreg[0]};
      4'hC: vreg[x] = rnd & kk;
      4'hD: return c8x_pkg::ST_LEFT_OUT;
      4'hE: begin
        if (kk == 8'h9E) skip_when(vreg[x] < 16 && keys[vreg[x][3:0]]);
        else if (kk == 8'hA1) skip_when(!(vreg[x] < 16 && keys[vreg[x][3:0]]));
        else return c8x_pkg::ST_UNKNOWN;
      end
      default: begin
        a = vreg[x];
        case (kk)
          8'h07: vreg[x] = dtimer;
          8'h0A: return c8x_pkg::ST_LEFT_OUT;
          8'h15: dtimer = a;
          8'h18: stimer = a;
          8'h1E: ireg = ireg + {8'd0, a};
          8'h29: ireg = 16'(a) * 16'(c8x_pkg::GlyphHeight);
          8'h33: begin
            mem[ireg[11:0]] = a / 100;
            mem[12'(ireg[11:0] + 1)] = (a / 10) % 10;
            mem[12'(ireg[11:0] + 2)] = a % 10;
          end
          8'h55: for (int i = 0; i <= x; i++) mem[12'(ireg[11:0] + i)] = vreg[i];
          8'h65: for (int i = 0; i <= x; i++) vreg[i] = mem[12'(ireg[11:0] + i)];
          default: return c8x_pkg::ST_UNKNOWN;
        endcase
      end
    endcase
    return c8x_pkg::ST_OK;
  endfunction

  // predict the result of one beat and queue it
  function automatic void predict_step(input c8x_pkg::in_item_t it);
    c8x_pkg::out_item_t e;
    logic [2:0] st;
    st = c8x_pkg::ST_OK;
    if (!it.mode) mem[it.load_address] = it.load_data;
    else st = run_opcode(it.opcode, it.key_mask, it.random_byte);
    e.program_counter = pc;
    e.index_value = ireg;
    e.flag_value = vreg[15];
    e.delay_value = dtimer;
    e.sound_value = stimer;
    e.status = st;
    expected_results.push_back(e);
  endfunction

  // stimulus-side shadow of I, used with mem_known so Fx65 only reads written bytes
  logic [15:0] gen_i;

  function automatic void push_load(input logic [11:0] adr, input logic [7:0] d);
    c8x_pkg::in_item_t it;
    it = '0;
    it.mode = 1'b0; it.load_address = adr; it.load_data = d;
    it.opcode = 16'($urandom); it.key_mask = 16'($urandom); it.random_byte = 8'($urandom);
    mem_known[adr] = 1'b1;
    pending_items.push_back(it);
  endfunction

  function automatic void push_op(input logic [15:0] op);
    c8x_pkg::in_item_t it;
    logic [3:0] x;
    it.mode = 1'b1; it.opcode = op;
    it.load_address = 12'($urandom); it.load_data = 8'($urandom);
    it.key_mask = 16'($urandom); it.random_byte = 8'($urandom);
    x = op[11:8];
    if (op[15:12] == 4'hA) gen_i = {4'd0, op[11:0]};
    if (op[15:12] == 4'hF && op[7:0] == 8'h33)
      for (int i = 0; i < 3; i++) mem_known[12'(gen_i[11:0] + i)] = 1'b1;
    if (op[15:12] == 4'hF && op[7:0] == 8'h55)
      for (int i = 0; i <= x; i++) mem_known[12'(gen_i[11:0] + i)] = 1'b1;
    pending_items.push_back(it);
  endfunction

  // random opcode; I-changing ops other than Annn are avoided so gen_i stays exact
  function automatic logic [15:0] rand_opcode();
    logic [15:0] op;
    logic [3:0] x;
    bit ok;
    x = 4'($urandom);
    case ($urandom_range(0, 17))
      0: op = ($urandom_range(0, 1)) ? 16'h00EE : 16'h00E0;
      1: op = {4'h1, 12'($urandom)};
      2, 3: op = {4'h2, 12'($urandom)};
      4: op = {4'h3, x, 8'($urandom)};
      5: op = {4'h4, x, 8'($urandom)};
      6: op = {4'h5, x, 4'($urandom), 4'($urandom_range(0, 3) == 0 ? $urandom : 0)};
      7: op = {4'h6, x, 8'($urandom)};
      8: op = {4'h7, x, 8'($urandom)};
      9, 10: op = {4'h8, x, 4'($urandom), 4'($urandom)};
      11: op = {4'h9, x, 4'($urandom), 4'($urandom_range(0, 3) == 0 ? $urandom : 0)};
      12: op = {4'hA, 12'($urandom)};
      13: op = {4'hB, 12'($urandom)};
      14: op = {4'hC, x, 8'($urandom)};
      15: op = {4'hE, x, ($urandom_range(0, 4) == 0) ? 8'($urandom) :
                 ($urandom_range(0, 1) ? 8'h9E : 8'hA1)};
      16: begin
        case ($urandom_range(0, 6))
          0: op = {4'hF, x, 8'h07};
          1: op = {4'hF, x, 8'h15};
          2: op = {4'hF, x, 8'h18};
          3: op = {4'hF, x, 8'h33};
          4: op = {4'hF, x, 8'h55};
          5: begin
            op = {4'hF, x, ($urandom_range(0, 1)) ? 8'h0A : 8'($urandom)};
            // a random block load could touch unwritten bytes
            if (op[7:0] == 8'h65) op = 16'h00E0;
          end
          default: begin
            ok = 1'b1;
            for (int i = 0; i <= x; i++) ok &= mem_known[12'(gen_i[11:0] + i)];
            op = ok ? {4'hF, x, 8'h65} : {4'hF, x, 8'h55};
          end
        endcase
        if (op[7:0] == 8'h1E || op[7:0] == 8'h29) op = 16'h00E0;
      end
      default: op = {4'hD, 12'($urandom)};
    endcase
    if (op[15:12] == 4'h0 && op != 16'h00E0 && op != 16'h00EE && $urandom_range(0, 3) == 0)
      op = {4'h0, 12'($urandom)};
    if (op[15:12] == 4'h0 && op[11:0] != 12'h0E0 && op[11:0] != 12'h0EE
        && $urandom_range(0, 1) == 0)
      op = 16'h00EE;
    return op;
  endfunction

  task automatic cfg_write(input logic [31:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {c8x_pkg::REG_START_ADDRESS, 2'b00}; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    pc = v[11:0];
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_step(in_data);
        void'(pending_items.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold the stalled beat
      end else if (pending_items.size() > (in_valid && !in_stall ? 0 : 0) &&
                   !(driver_idle_en && $urandom_range(0, 99) < 15)) begin
        in_valid <= 1'b1;
        in_data <= pending_items[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    c8x_pkg::out_item_t e;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", out_data);
        end else begin
          e = expected_results.pop_front();
          if (out_data !== e) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, out_data);
          end
        end
      end
      if (hold_out) begin
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= driver_idle_en && $urandom_range(0, 99) < 15;
      end
    end
  end

  initial begin
    logic [11:0] starts [4];
    clk = 1'b0;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    mismatches = 0; cycles = 0; driver_idle_en = 1'b1; hold_out = 1'b0; hold_left = 0;
    for (int i = 0; i < 16; i++) begin vreg[i] = '0; rstack[i] = '0; end
    for (int i = 0; i < 4096; i++) begin mem[i] = '0; mem_known[i] = 1'b0; end
    ireg = '0; pc = c8x_pkg::StartAddrRst; depth = 0; dtimer = '0; stimer = '0; gen_i = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at reset start address
    push_load(12'h000, 8'h00);
    push_load(12'hFFF, 8'hFF);
    push_op(16'h00EE);
    push_op(16'h00E0);
    push_op(16'h0123);
    push_op(16'h60FF);
    push_op(16'h7F01);
    push_op(16'h61FF);
    push_op(16'h8014);
    push_op(16'h8F15);
    push_op(16'h8106);
    push_op(16'h81FE);
    push_op(16'h8107);
    push_op(16'h8018);
    push_op(16'h5011);
    push_op(16'h6214);
    push_op(16'hE29E);
    push_op(16'hE2A1);
    push_op(16'hAFFE);
    push_op(16'hF155);
    push_op(16'hF065);
    push_op(16'hF233);
    push_op(16'hBFFF);
    push_op(16'hC3FF);
    push_op(16'hFF99);
    for (int i = 0; i < 17; i++) push_op({4'h2, 12'($urandom)});
    for (int i = 0; i < 17; i++) push_op(16'h00EE);
    drain();

    starts[0] = 12'hFFF; starts[1] = 12'h000; starts[2] = 12'h200;
    starts[3] = 12'($urandom);
    for (int ph = 0; ph < 4; ph++) begin
      cfg_write({20'd0, starts[ph]});
      driver_idle_en = (ph != 1);
      if (ph == 2) begin
        hold_out = 1'b1;
        hold_left = 300;
      end
      for (int k = 0; k < 173; k++) begin
        if ($urandom_range(0, 9) == 0) push_load(12'($urandom), 8'($urandom));
        else push_op(rand_opcode());
      end
      if (ph == 2) begin
        repeat (300) @(posedge clk);
        hold_out = 1'b0;
      end
      drain();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
